[hdl/vfcm_pkg.sv]
// Shared types, codes and corner tables of the voxel face-cull mesher.
package vfcm_pkg;

	// Input mode codes (s_tuser)
	localparam logic [1:0] MODE_GRID   = 2'd0;
	localparam logic [1:0] MODE_BORDER = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	// Border plane codes
	localparam logic [1:0] SIDE_FRONT = 2'd0;
	localparam logic [1:0] SIDE_BACK  = 2'd1;
	localparam logic [1:0] SIDE_RIGHT = 2'd2;
	localparam logic [1:0] SIDE_LEFT  = 2'd3;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 56;
	localparam logic [2:0] LAST_VTX = 3'd5;

	// Row read selection: which neighbor row the memories are reading
	typedef enum logic [2:0] {
		RS_NONE = 3'd0,
		RS_C    = 3'd1,
		RS_U    = 3'd2,
		RS_D    = 3'd3,
		RS_R    = 3'd4,
		RS_L    = 3'd5
	} rsel_t;

	typedef struct packed {
		logic  clr;
		logic  capture;
		rsel_t rsel;
		logic  eval;
		logic  emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic query_ok;
		logic faces_left;
	} dp_sts_t;

	// Corner sign bits: bit0 x, bit1 y, bit2 z; set means +half
	localparam logic [2:0] CORNER_SIGN [0:7] = '{
		3'd7, 3'd6, 3'd4, 3'd5, 3'd2, 3'd3, 3'd1, 3'd0
	};

	// Corner order per face: top, bottom, right, left, front, back
	localparam logic [2:0] FACE_CORNERS [0:5][0:5] = '{
		'{3'd0, 3'd5, 3'd4, 3'd4, 3'd1, 3'd0},
		'{3'd3, 3'd2, 3'd7, 3'd7, 3'd6, 3'd3},
		'{3'd0, 3'd3, 3'd6, 3'd6, 3'd5, 3'd0},
		'{3'd1, 3'd4, 3'd7, 3'd7, 3'd2, 3'd1},
		'{3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd0},
		'{3'd5, 3'd4, 3'd7, 3'd7, 3'd6, 3'd5}
	};

	// Texture coordinate per vertex slot, bit i = slot i
	localparam logic [5:0] UV_U = 6'b001110;
	localparam logic [5:0] UV_V = 6'b011100;

endpackage

[hdl/vfcm_ctrl.sv]
// Controller state machine of the voxel face-cull mesher.
module vfcm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  vfcm_pkg::dp_sts_t  sts,
	output vfcm_pkg::ctl_cmd_t cmd,
	output logic               s_tready
);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_RD_C  = 10'b0000000100,
		ST_RD_U  = 10'b0000001000,
		ST_RD_D  = 10'b0000010000,
		ST_RD_R  = 10'b0000100000,
		ST_RD_L  = 10'b0001000000,
		ST_RD_W  = 10'b0010000000,
		ST_EVAL  = 10'b0100000000,
		ST_EMIT  = 10'b1000000000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		cmd.clr     = 1'b0;
		cmd.capture = 1'b0;
		cmd.rsel    = vfcm_pkg::RS_NONE;
		cmd.eval    = 1'b0;
		cmd.emit    = 1'b0;
		s_tready    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid && sts.query_ok) state_nxt = ST_RD_C;
			end
			ST_RD_C: begin
				cmd.rsel  = vfcm_pkg::RS_C;
				state_nxt = ST_RD_U;
			end
			ST_RD_U: begin
				cmd.rsel  = vfcm_pkg::RS_U;
				state_nxt = ST_RD_D;
			end
			ST_RD_D: begin
				cmd.rsel  = vfcm_pkg::RS_D;
				state_nxt = ST_RD_R;
			end
			ST_RD_R: begin
				cmd.rsel  = vfcm_pkg::RS_R;
				state_nxt = ST_RD_L;
			end
			ST_RD_L: begin
				cmd.rsel  = vfcm_pkg::RS_L;
				state_nxt = ST_RD_W;
			end
			ST_RD_W: begin
				state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (!sts.faces_left) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

endmodule

[hdl/vfcm_datapath.sv]
// Datapath of the voxel face-cull mesher: cell memories, lookup, vertex generator.
module vfcm_datapath #(
	parameter int WIDTH  = 16,
	parameter int HEIGHT = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  vfcm_pkg::ctl_cmd_t                   cmd,
	output vfcm_pkg::dp_sts_t                    sts,
	input  logic [1:0]                           in_mode,
	input  logic [vfcm_pkg::IN_DATA_W-1:0]       in_data,
	input  logic                                 cfg_we,
	input  logic [3:0]                           cfg_wdata,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [vfcm_pkg::OUT_DATA_W-1:0]      out_data,
	output logic                                 out_last
);

	localparam int IW        = $clog2(WIDTH);
	localparam int YW        = $clog2(HEIGHT);
	localparam int GRID_ROWS = WIDTH * HEIGHT;
	localparam int BRD_ROWS  = 4 * HEIGHT;
	localparam int GA_W      = $clog2(GRID_ROWS);
	localparam int BA_W      = $clog2(BRD_ROWS);
	localparam int CLR_N     = (GRID_ROWS > BRD_ROWS) ? GRID_ROWS : BRD_ROWS;
	localparam int CLR_W     = $clog2(CLR_N);

	// input fields
	logic [3:0] f_x, f_z;
	logic [5:0] f_y;
	logic [1:0] f_side;
	logic       f_solid;
	assign f_x     = in_data[3:0];
	assign f_y     = in_data[9:4];
	assign f_z     = in_data[13:10];
	assign f_side  = in_data[15:14];
	assign f_solid = in_data[16];

	logic x_ok, y_ok, z_ok, col_ok;
	logic [3:0] f_col;
	assign x_ok   = int'(f_x) < WIDTH;
	assign y_ok   = int'(f_y) < HEIGHT;
	assign z_ok   = int'(f_z) < WIDTH;
	assign f_col  = (f_side == vfcm_pkg::SIDE_FRONT || f_side == vfcm_pkg::SIDE_BACK) ? f_x : f_z;
	assign col_ok = int'(f_col) < WIDTH;

	assign sts.query_ok = (in_mode == vfcm_pkg::MODE_QUERY) && x_ok && y_ok && z_ok;

	logic gw_en, bw_en;
	logic [GA_W-1:0] gw_addr;
	logic [BA_W-1:0] bw_addr;
	assign gw_en   = cmd.capture && (in_mode == vfcm_pkg::MODE_GRID) && x_ok && y_ok && z_ok;
	assign bw_en   = cmd.capture && (in_mode == vfcm_pkg::MODE_BORDER) && y_ok && col_ok;
	assign gw_addr = GA_W'(IW'(f_x)) * GA_W'(HEIGHT) + GA_W'(YW'(f_y));
	assign bw_addr = BA_W'(f_side) * BA_W'(HEIGHT) + BA_W'(YW'(f_y));

	// clearing sweep
	logic [CLR_W-1:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign sts.clr_done = cmd.clr && (clr_q == CLR_W'(CLR_N - 1));

	// query coordinates
	logic [3:0] qx_q, qz_q;
	logic [5:0] qy_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			qx_q <= f_x;
			qy_q <= f_y;
			qz_q <= f_z;
		end
	end

	logic [IW-1:0] x_i, z_i;
	logic [YW-1:0] y_i;
	assign x_i = IW'(qx_q);
	assign z_i = IW'(qz_q);
	assign y_i = YW'(qy_q);

	// read address selection
	logic [IW-1:0] rx;
	logic [YW-1:0] ry;
	logic [1:0]    rside;
	logic [GA_W-1:0] gr_addr;
	logic [BA_W-1:0] br_addr;
	always_comb begin
		rx    = x_i;
		ry    = y_i;
		rside = vfcm_pkg::SIDE_FRONT;
		unique case (cmd.rsel)
			vfcm_pkg::RS_U: begin
				if (y_i != YW'(HEIGHT - 1)) ry = y_i + 1'b1;
				rside = vfcm_pkg::SIDE_BACK;
			end
			vfcm_pkg::RS_D: begin
				if (y_i != '0) ry = y_i - 1'b1;
				rside = vfcm_pkg::SIDE_RIGHT;
			end
			vfcm_pkg::RS_R: begin
				if (x_i != IW'(WIDTH - 1)) rx = x_i + 1'b1;
				rside = vfcm_pkg::SIDE_LEFT;
			end
			vfcm_pkg::RS_L: begin
				if (x_i != '0) rx = x_i - 1'b1;
			end
			default: begin
			end
		endcase
	end
	assign gr_addr = GA_W'(rx) * GA_W'(HEIGHT) + GA_W'(ry);
	assign br_addr = BA_W'(rside) * BA_W'(HEIGHT) + BA_W'(y_i);

	// memories: one row of WIDTH cells per word
	logic [WIDTH-1:0] grid_mem [GRID_ROWS];
	logic [WIDTH-1:0] brd_mem  [BRD_ROWS];
	logic [WIDTH-1:0] grow_q, brow_q;

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			if ({1'b0, clr_q} < (CLR_W + 1)'(GRID_ROWS)) grid_mem[GA_W'(clr_q)] <= '0;
		end else if (gw_en) begin
			grid_mem[gw_addr][IW'(f_z)] <= f_solid;
		end
		grow_q <= grid_mem[gr_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			if ({1'b0, clr_q} < (CLR_W + 1)'(BRD_ROWS)) brd_mem[BA_W'(clr_q)] <= '0;
		end else if (bw_en) begin
			brd_mem[bw_addr][IW'(f_col)] <= f_solid;
		end
		brow_q <= brd_mem[br_addr];
	end

	// neighbor bits, captured in the cycle after each read
	vfcm_pkg::rsel_t rsel_s1;
	logic solid_q, zp_q, zm_q, up_q, dn_q, rt_q, lf_q;
	logic bf_q, bb_q, br_q, bl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsel_s1 <= vfcm_pkg::RS_NONE;
		end else begin
			rsel_s1 <= cmd.rsel;
		end
	end

	always_ff @(posedge clk) begin
		unique case (rsel_s1)
			vfcm_pkg::RS_C: begin
				solid_q <= grow_q[z_i];
				zp_q    <= (z_i != IW'(WIDTH - 1)) ? grow_q[IW'(z_i + 1'b1)] : 1'b0;
				zm_q    <= (z_i != '0) ? grow_q[IW'(z_i - 1'b1)] : 1'b0;
				bf_q    <= brow_q[x_i];
			end
			vfcm_pkg::RS_U: begin
				up_q <= grow_q[z_i];
				bb_q <= brow_q[x_i];
			end
			vfcm_pkg::RS_D: begin
				dn_q <= grow_q[z_i];
				br_q <= brow_q[z_i];
			end
			vfcm_pkg::RS_R: begin
				rt_q <= grow_q[z_i];
				bl_q <= brow_q[z_i];
			end
			vfcm_pkg::RS_L: begin
				lf_q <= grow_q[z_i];
			end
			default: begin
			end
		endcase
	end

	// neighbor-present register
	logic [3:0] np_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q <= '0;
		end else if (cfg_we) begin
			np_q <= cfg_wdata;
		end
	end

	// exposed-face mask
	logic [5:0] mask;
	always_comb begin
		mask[0] = (y_i == YW'(HEIGHT - 1)) || !up_q;
		mask[1] = (y_i == '0) || !dn_q;
		mask[2] = (x_i != IW'(WIDTH - 1)) ? !rt_q : (np_q[vfcm_pkg::SIDE_RIGHT] && !br_q);
		mask[3] = (x_i != '0) ? !lf_q : (np_q[vfcm_pkg::SIDE_LEFT] && !bl_q);
		mask[4] = (z_i != IW'(WIDTH - 1)) ? !zp_q : (np_q[vfcm_pkg::SIDE_FRONT] && !bf_q);
		mask[5] = (z_i != '0) ? !zm_q : (np_q[vfcm_pkg::SIDE_BACK] && !bb_q);
	end

	// vertex generator
	logic [5:0]  open_q;
	logic [2:0]  vtx_q;
	logic [23:0] vcnt_q;
	logic        ovalid_q;
	logic [vfcm_pkg::OUT_DATA_W-1:0] odata_q;
	logic        olast_q;

	logic [2:0] fdir;
	always_comb begin
		fdir = 3'd0;
		for (int i = 5; i >= 0; i--) begin
			if (open_q[i]) fdir = 3'(i);
		end
	end

	logic [2:0] sg;
	logic [5:0] px, pz;
	logic [7:0] py;
	logic [5:0] open_rest;
	logic       adv, is_last;
	assign sg        = vfcm_pkg::CORNER_SIGN[vfcm_pkg::FACE_CORNERS[fdir][vtx_q]];
	assign px        = {1'b0, qx_q, 1'b0} + (sg[0] ? 6'd1 : 6'h3F);
	assign py        = {1'b0, qy_q, 1'b0} + (sg[1] ? 8'd1 : 8'hFF);
	assign pz        = {1'b0, qz_q, 1'b0} + (sg[2] ? 6'd1 : 6'h3F);
	assign open_rest = open_q & (open_q - 1'b1);
	assign is_last   = (vtx_q == vfcm_pkg::LAST_VTX) && (open_rest == '0);
	assign adv       = cmd.emit && (open_q != '0) && (!ovalid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= '0;
			vtx_q    <= '0;
			vcnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				open_q <= solid_q ? mask : 6'd0;
				vtx_q  <= '0;
			end else if (adv) begin
				if (vtx_q == vfcm_pkg::LAST_VTX) begin
					vtx_q  <= '0;
					open_q <= open_rest;
				end else begin
					vtx_q <= vtx_q + 1'b1;
				end
			end
			if (adv) begin
				vcnt_q   <= vcnt_q + 1'b1;
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			odata_q <= {7'd0, fdir, vfcm_pkg::UV_V[vtx_q], vfcm_pkg::UV_U[vtx_q],
				pz, py, px, vcnt_q};
			olast_q <= is_last;
		end
	end

	assign sts.faces_left = open_q != '0;
	assign out_valid      = ovalid_q;
	assign out_data       = odata_q;
	assign out_last       = olast_q;

endmodule

[hdl/voxel_face_cull_mesher.sv]
// Flow: a write request is stored as it is accepted; a query reads its rows, evaluates the faces,
// then gives 6 vertices per exposed face at one per cycle unless the vertex channel stalls.
// The lookup length is set by the single read port of the grid memory (five rows read).
// Throughput: one request at a time; the last vertex may wait while the next request enters.
// Reset (arst_n, async low): a clearing pass over every row zeroes
module voxel_face_cull_mesher #(
	parameter int WIDTH  = 16,
	parameter int HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	// cell_x[3:0], cell_y[9:4], cell_z[13:10], side[15:14], solid_in[16], zero pad
	input  logic [23:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	// vertex channel
	output logic        m_tvalid,
	input  logic        m_tready,
	// vertex_index[23:0], pos_x2[29:24], pos_y2[37:30], pos_z2[43:38], tex_u[44],
	// tex_v[45], face_dir[48:46], zero pad
	output logic [55:0] m_tdata,
	// last vertex of the query
	output logic        m_tlast,
	// neighbor_present: bit0 front, bit1 back, bit2 right, bit3 left
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata
);

	// the grid and border memories; no request is taken until it ends, config writes still are.

	vfcm_pkg::ctl_cmd_t cmd;
	vfcm_pkg::dp_sts_t  sts;

	// Controller: clear sweep, request accept, five row reads, face evaluation, emission.
	vfcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	// Datapath: rows of WIDTH cells per memory word; the center row gives the cell and its
	// z neighbors, four more rows give y and x neighbors, border rows are read alongside.
	vfcm_datapath #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_mode   (s_tuser),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

`ifndef SYNTHESIS
	// a query that enters blocks further requests until it is done
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.capture && sts.query_ok) |=> !s_tready)
		else $error("request taken right after a query");

	// no request is taken while faces of a query are still pending
	a_faces_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.faces_left |-> !s_tready)
		else $error("request taken during emission");

	// a new vertex only appears while emitting
	a_vertex_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.emit))
		else $error("vertex outside emission");

	// the clearing pass never overlaps a request
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !s_tready)
		else $error("request accepted during clearing");
`endif

endmodule
